// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property at every rising edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== rtl/ccbo_pkg.sv =====
// Shared types and constants of the CSR column block offset generator.
package ccbo_pkg;

   localparam int DATA_BITS          = 32;
   localparam int REQ_TYPE_BITS      = 2;
   localparam int GROUP_NUM_BITS     = 4;
   localparam int GRID_BITS          = 5;
   localparam int WIDE_BITS          = 4;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 32;
   localparam int DEFAULT_MAX_GROUPS = 16;
   localparam int DEFAULT_INDEX_BITS = 32;
   localparam int MID_DEPTH          = 2;
   localparam int OUT_DEPTH          = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_COLS   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GROUP_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDE_GROUPS = 2'd2;

   localparam logic [GRID_BITS-1:0] GRID_COLS_RESET   = 5'd1;
   localparam logic [DATA_BITS-1:0] GROUP_WIDTH_RESET = 32'd1;
   localparam logic [WIDE_BITS-1:0] WIDE_GROUPS_RESET = 4'd0;

   typedef enum logic [REQ_TYPE_BITS-1:0] {
      REQ_ENTRY      = 2'd0,
      REQ_ROW_END    = 2'd1,
      REQ_MATRIX_END = 2'd2
   } req_kind_type;

   typedef struct packed {
      req_kind_type         kind;
      logic [DATA_BITS-1:0] column;
   } item_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]      offset;
      logic [DATA_BITS-1:0]      row_number;
      logic [GROUP_NUM_BITS-1:0] group_number;
      logic                      is_final;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic [GRID_BITS-1:0] grid_cols;
      logic [DATA_BITS-1:0] group_width;
      logic [WIDE_BITS-1:0] wide_groups;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_DISPATCH,
      ST_SCAN,
      ST_CLOSE,
      ST_FINAL
   } back_state_type;

endpackage

// ===== rtl/ccbo_fifo.sv =====
// Small first-in first-out queue built from registers.
module ccbo_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_wr;
   logic                do_rd;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/ccbo_front.sv =====
// Front end: takes request transfers, classifies them and drops unknown types.
module ccbo_front (
   input  logic                                    push,
   output logic                                    full,
   input  logic [ccbo_pkg::REQ_TYPE_BITS-1:0]      req_type,
   input  logic [ccbo_pkg::DATA_BITS-1:0]          req_column,
   output logic                                    q_push,
   output ccbo_pkg::item_type                      q_item,
   input  logic                                    q_full
);

   logic known;

   // Only entries, row ends and matrix ends reach the back end.
   assign known = (req_type == ccbo_pkg::REQ_ENTRY)
               || (req_type == ccbo_pkg::REQ_ROW_END)
               || (req_type == ccbo_pkg::REQ_MATRIX_END);

   assign full          = q_full;
   assign q_push        = push && !q_full && known;
   assign q_item.kind   = ccbo_pkg::req_kind_type'(req_type);
   assign q_item.column = req_column;

endmodule

// ===== rtl/ccbo_back.sv =====
// Back end: walks column groups and emits at most one offset per cycle while the result queue has room.
module ccbo_back #(
   parameter int MAX_GROUPS = ccbo_pkg::DEFAULT_MAX_GROUPS,
   parameter int INDEX_BITS = ccbo_pkg::DEFAULT_INDEX_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  ccbo_pkg::cfg_type   cfg,
   input  logic                item_valid,
   input  ccbo_pkg::item_type  item,
   output logic                item_pop,
   input  logic                out_full,
   output logic                out_push,
   output ccbo_pkg::rsp_type   out_data
);

   localparam int GRP_BITS   = $clog2(MAX_GROUPS + 1);
   localparam int CNT_BITS   = $clog2(MAX_GROUPS + 2);
   localparam int CMP_BITS   = (CNT_BITS > ccbo_pkg::GRID_BITS) ? CNT_BITS : ccbo_pkg::GRID_BITS;
   localparam int START_BITS = ccbo_pkg::DATA_BITS + GRP_BITS;

   ccbo_pkg::back_state_type state_ff, state_in;
   logic [INDEX_BITS-1:0]    entry_ff, entry_in;
   logic [INDEX_BITS-1:0]    row_ff, row_in;
   logic [GRP_BITS-1:0]      group_ff, group_in;
   logic [START_BITS-1:0]    start_ff, start_in;
   logic                     open_ff, open_in;
   logic                     eom_ff, eom_in;

   logic [CMP_BITS-1:0]      grid_ext;
   logic [CMP_BITS-1:0]      groups;
   logic [CMP_BITS-1:0]      group_ext;
   logic [CMP_BITS-1:0]      group_nxt;
   logic [CMP_BITS-1:0]      wide_ext;
   logic                     lt_wide;
   logic [START_BITS-1:0]    start_calc;
   logic [START_BITS-1:0]    start_next;
   logic [START_BITS-1:0]    col_ext;
   logic                     hit_cur;
   logic                     hit_next;
   logic                     close_last;
   logic                     close_done;
   logic                     emit;
   logic [INDEX_BITS-1:0]    entry_sat;
   logic [INDEX_BITS-1:0]    row_sat;

   // Clamp the group count into 1..MAX_GROUPS.
   assign grid_ext = CMP_BITS'(cfg.grid_cols);
   always_comb begin
      if (grid_ext == '0) begin
         groups = CMP_BITS'(1);
      end else if (grid_ext > CMP_BITS'(MAX_GROUPS)) begin
         groups = CMP_BITS'(MAX_GROUPS);
      end else begin
         groups = grid_ext;
      end
   end

   assign group_ext = CMP_BITS'(group_ff);
   assign group_nxt = group_ext + 1'b1;
   assign wide_ext  = CMP_BITS'(cfg.wide_groups);
   assign lt_wide   = group_ext < wide_ext;

   // Start column of the pending group, from scratch or one group further on.
   assign start_calc = START_BITS'(group_ff) * START_BITS'(cfg.group_width)
                     + START_BITS'(lt_wide ? group_ext : wide_ext);
   assign start_next = start_ff + START_BITS'(cfg.group_width) + START_BITS'(lt_wide);
   assign col_ext    = START_BITS'(item.column);

   assign hit_cur    = (group_ext < groups) && (col_ext >= start_ff);
   assign hit_next   = (group_nxt < groups) && (col_ext >= start_next);
   assign close_last = (group_nxt >= groups);

   assign entry_sat = (&entry_ff) ? entry_ff : entry_ff + 1'b1;
   assign row_sat   = (&row_ff) ? row_ff : row_ff + 1'b1;

   assign out_push = emit && !out_full;

   always_comb begin
      state_in   = state_ff;
      entry_in   = entry_ff;
      row_in     = row_ff;
      group_in   = group_ff;
      start_in   = start_ff;
      open_in    = open_ff;
      eom_in     = eom_ff;
      item_pop   = 1'b0;
      emit       = 1'b0;
      close_done = 1'b0;
      out_data.offset       = ccbo_pkg::DATA_BITS'(entry_ff);
      out_data.row_number   = ccbo_pkg::DATA_BITS'(row_ff);
      out_data.group_number = ccbo_pkg::GROUP_NUM_BITS'(group_ff);
      out_data.is_final     = 1'b0;
      out_data.last         = 1'b0;

      case (state_ff)
         ccbo_pkg::ST_DISPATCH: begin
            if (item_valid) begin
               case (item.kind)
                  ccbo_pkg::REQ_ENTRY: begin
                     if (open_ff) begin
                        start_in = start_calc;
                     end else begin
                        // open the row: group 0 starts at column 0, always hit
                        group_in = '0;
                        start_in = '0;
                        open_in  = 1'b1;
                     end
                     state_in = ccbo_pkg::ST_SCAN;
                  end
                  ccbo_pkg::REQ_ROW_END: begin
                     if (!open_ff) begin
                        group_in = '0;
                     end
                     eom_in   = 1'b0;
                     state_in = ccbo_pkg::ST_CLOSE;
                  end
                  ccbo_pkg::REQ_MATRIX_END: begin
                     eom_in   = 1'b1;
                     state_in = open_ff ? ccbo_pkg::ST_CLOSE : ccbo_pkg::ST_FINAL;
                  end
                  default: begin
                     item_pop = 1'b1;
                  end
               endcase
            end
         end
         ccbo_pkg::ST_SCAN: begin
            if (hit_cur) begin
               emit          = 1'b1;
               out_data.last = !hit_next;
               if (!out_full) begin
                  group_in = GRP_BITS'(group_nxt);
                  start_in = start_next;
                  if (!hit_next) begin
                     entry_in = entry_sat;
                     item_pop = 1'b1;
                     state_in = ccbo_pkg::ST_DISPATCH;
                  end
               end
            end else begin
               entry_in = entry_sat;
               item_pop = 1'b1;
               state_in = ccbo_pkg::ST_DISPATCH;
            end
         end
         ccbo_pkg::ST_CLOSE: begin
            if (group_ext < groups) begin
               emit          = 1'b1;
               out_data.last = close_last && !eom_ff;
               if (!out_full) begin
                  group_in   = GRP_BITS'(group_nxt);
                  close_done = close_last;
               end
            end else begin
               close_done = 1'b1;
            end
            if (close_done) begin
               row_in   = row_sat;
               open_in  = 1'b0;
               group_in = '0;
               if (eom_ff) begin
                  state_in = ccbo_pkg::ST_FINAL;
               end else begin
                  item_pop = 1'b1;
                  state_in = ccbo_pkg::ST_DISPATCH;
               end
            end
         end
         ccbo_pkg::ST_FINAL: begin
            emit                  = 1'b1;
            out_data.group_number = '0;
            out_data.is_final     = 1'b1;
            out_data.last         = 1'b1;
            if (!out_full) begin
               entry_in = '0;
               row_in   = '0;
               group_in = '0;
               start_in = '0;
               open_in  = 1'b0;
               item_pop = 1'b1;
               state_in = ccbo_pkg::ST_DISPATCH;
            end
         end
         default: begin
            state_in = ccbo_pkg::ST_DISPATCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccbo_pkg::ST_DISPATCH;
         entry_ff <= '0;
         row_ff   <= '0;
         group_ff <= '0;
         open_ff  <= 1'b0;
         eom_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         entry_ff <= entry_in;
         row_ff   <= row_in;
         group_ff <= group_in;
         open_ff  <= open_in;
         eom_ff   <= eom_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
   end

endmodule

// ===== rtl/csr_column_block_offsets_top.sv =====
// Top level of the CSR column block offset generator.
//
// Usage: the request side is a queue input. A transfer happens at a rising
// edge with push high and full low; req_type selects a nonzero entry (with
// req_column), an end of row or an end of matrix. Other type codes are taken
// and dropped. The result side is a queue output: while empty is low the
// oldest offset sits on the rsp_ ports, and a transfer happens at a rising
// edge with pop high. rsp_last marks the last offset caused by one request.
// Configuration: csr_write_en writes csr_wdata into register csr_index
// (0 group count, 1 group width, 2 wide groups) at the rising edge. Write
// only while no request is in flight; the block itself does not enforce it.
// Timing: a request lands in a two-entry queue; the group walker takes a
// nonzero entry in a dispatch state, then a scan state that emits one offset
// for each group it crosses; an end of row passes the dispatch state and a
// close state that emits one offset per group left, if any; an end of matrix
// adds a final state for the total. The walker emits at most one offset per
// cycle while the result queue has room, which sets throughput. An offset
// reaches the result ports through the request queue, walker and result queue.
// Reset (synchronous, active high) empties both queues, clears the counters,
// closes any open row and loads group count 1, width 1, no wide groups.
// When the receiver stalls, the result queue fills, the walker holds, then
// the request queue fills and full rises.
module csr_column_block_offsets_top #(
   parameter int MAX_GROUPS = ccbo_pkg::DEFAULT_MAX_GROUPS,
   parameter int INDEX_BITS = ccbo_pkg::DEFAULT_INDEX_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   push,
   output logic                                   full,
   input  logic [ccbo_pkg::REQ_TYPE_BITS-1:0]     req_type,
   input  logic [ccbo_pkg::DATA_BITS-1:0]         req_column,
   // result channel
   output logic                                   empty,
   input  logic                                   pop,
   output logic [ccbo_pkg::DATA_BITS-1:0]         rsp_offset,
   output logic [ccbo_pkg::DATA_BITS-1:0]         rsp_row_number,
   output logic [ccbo_pkg::GROUP_NUM_BITS-1:0]    rsp_group_number,
   output logic                                   rsp_is_final,
   output logic                                   rsp_last,
   // configuration port
   input  logic                                   csr_write_en,
   input  logic [ccbo_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ccbo_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int ITEM_BITS = $bits(ccbo_pkg::item_type);
   localparam int RSP_BITS  = $bits(ccbo_pkg::rsp_type);

   // Configuration registers.
   ccbo_pkg::cfg_type  cfg_ff, cfg_in;

   // Front to back queue.
   logic               mid_push;
   logic               mid_full;
   logic               mid_empty;
   logic               mid_pop;
   ccbo_pkg::item_type mid_wr_item;
   ccbo_pkg::item_type mid_rd_item;

   // Back to result queue.
   logic               out_push;
   logic               out_full;
   ccbo_pkg::rsp_type  out_wr_rsp;
   ccbo_pkg::rsp_type  out_rd_rsp;

   // Load the addressed register; an index past the list writes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            ccbo_pkg::CSR_GRID_COLS:   cfg_in.grid_cols   = csr_wdata[ccbo_pkg::GRID_BITS-1:0];
            ccbo_pkg::CSR_GROUP_WIDTH: cfg_in.group_width = csr_wdata[ccbo_pkg::DATA_BITS-1:0];
            ccbo_pkg::CSR_WIDE_GROUPS: cfg_in.wide_groups = csr_wdata[ccbo_pkg::WIDE_BITS-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_cols   <= ccbo_pkg::GRID_COLS_RESET;
         cfg_ff.group_width <= ccbo_pkg::GROUP_WIDTH_RESET;
         cfg_ff.wide_groups <= ccbo_pkg::WIDE_GROUPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify requests and drop unknown codes.
   ccbo_front u_front (
      .push       (push),
      .full       (full),
      .req_type   (req_type),
      .req_column (req_column),
      .q_push     (mid_push),
      .q_item     (mid_wr_item),
      .q_full     (mid_full)
   );

   // Decouple request intake from the group walker.
   ccbo_fifo #(
      .WIDTH (ITEM_BITS),
      .DEPTH (ccbo_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mid_push),
      .wr_data (mid_wr_item),
      .full    (mid_full),
      .rd_en   (mid_pop),
      .rd_data (mid_rd_item),
      .empty   (mid_empty)
   );

   // Walk column groups and produce offsets.
   ccbo_back #(
      .MAX_GROUPS (MAX_GROUPS),
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (!mid_empty),
      .item       (mid_rd_item),
      .item_pop   (mid_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_data   (out_wr_rsp)
   );

   // Hold results while the receiver stalls.
   ccbo_fifo #(
      .WIDTH (RSP_BITS),
      .DEPTH (ccbo_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_wr_rsp),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (out_rd_rsp),
      .empty   (empty)
   );

   assign rsp_offset       = out_rd_rsp.offset;
   assign rsp_row_number   = out_rd_rsp.row_number;
   assign rsp_group_number = out_rd_rsp.group_number;
   assign rsp_is_final     = out_rd_rsp.is_final;
   assign rsp_last         = out_rd_rsp.last;

endmodule

// ===== rtl/ccbo_checker.sv =====
// Port-level checks of the offset generator, bound to its top level.
`include "assert_macros.svh"

module ccbo_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic                                full,
   input  logic                                empty,
   input  logic                                pop,
   input  logic [ccbo_pkg::DATA_BITS-1:0]      rsp_offset,
   input  logic [ccbo_pkg::GROUP_NUM_BITS-1:0] rsp_group_number,
   input  logic                                rsp_is_final,
   input  logic                                rsp_last
);

   // Reset leaves both queues empty.
   `ASSERT_CLK(a_reset_clears, clock, reset |=> empty && !full, "queues not cleared by reset")

   // The closing total always ends its request and names group zero.
   `ASSERT_CLK_RST(a_final_shape, clock, reset, !empty && rsp_is_final |-> rsp_last && rsp_group_number == 4'd0, "final result malformed")

   // A stalled result holds.
   `ASSERT_CLK_RST(a_stall_hold, clock, reset, !empty && !pop |=> !empty && $stable(rsp_offset) && $stable(rsp_last), "stalled result changed")

   // After a result that is not last, the next one is already queued.
   `ASSERT_CLK_RST(a_burst_gapless, clock, reset, !empty && pop && !rsp_last |=> !empty, "gap inside a result burst")

endmodule

bind csr_column_block_offsets_top ccbo_checker u_ccbo_checker (.*);

// ===== tb/sv/csr_column_block_offsets_top_test.sv =====
// Self-checking testbench for the CSR column block offset generator.
`timescale 1ns / 1ps

module csr_column_block_offsets_top_test;
   import ccbo_pkg::*;

   localparam int          RESET_CYCLES  = 10;
   localparam int          SETTLE_CYCLES = 32;     // covers a full group walk plus queues
   localparam int          HOLD_CYCLES   = 300;    // long receiver hold-off
   localparam int          RANDOM_ITEMS  = 100;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int          REPORT_LIMIT  = 10;
   localparam int          PLAN_ROWS     = 37;

   // A type code the block takes and drops.
   localparam logic [REQ_TYPE_BITS-1:0] REQ_UNKNOWN = 2'd3;
   localparam rsp_type NO_RSP = '0;

   typedef enum logic {STEP_ITEM, STEP_CSR} step_action_t;

   // One row of the directed plan: a request or a register write. Where the
   // expected offset is obvious it is typed in; otherwise the walker model
   // below supplies it.
   typedef struct {
      step_action_t          action;
      logic [1:0]            code;     // request type or register index
      logic [DATA_BITS-1:0]  value;    // column or register data
      bit                    typed;
      rsp_type               want;
   } plan_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      push         = 1'b0;
   logic                      full;
   logic [REQ_TYPE_BITS-1:0]  req_type     = '0;
   logic [DATA_BITS-1:0]      req_column   = '0;
   logic                      empty;
   logic                      pop          = 1'b0;
   logic [DATA_BITS-1:0]      rsp_offset;
   logic [DATA_BITS-1:0]      rsp_row_number;
   logic [GROUP_NUM_BITS-1:0] rsp_group_number;
   logic                      rsp_is_final;
   logic                      rsp_last;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index    = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata    = '0;

   csr_column_block_offsets_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_type         (req_type),
      .req_column       (req_column),
      .empty            (empty),
      .pop              (pop),
      .rsp_offset       (rsp_offset),
      .rsp_row_number   (rsp_row_number),
      .rsp_group_number (rsp_group_number),
      .rsp_is_final     (rsp_is_final),
      .rsp_last         (rsp_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 4 ns clock period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Group walker model: register copy and walker state, all at reset.
   // ------------------------------------------------------------------
   logic [GRID_BITS-1:0] cfg_grid_cols   = GRID_COLS_RESET;
   logic [DATA_BITS-1:0] cfg_group_width = GROUP_WIDTH_RESET;
   logic [WIDE_BITS-1:0] cfg_wide_groups = WIDE_GROUPS_RESET;

   logic [DATA_BITS-1:0] nnz_seen        = '0;
   logic [DATA_BITS-1:0] rows_closed     = '0;
   logic [GRID_BITS-1:0] pending_group   = '0;
   logic [63:0]          pending_start   = '0;
   bit                   row_in_progress = 1'b0;

   rsp_type fresh_offsets[$];     // offsets caused by the request just taken
   rsp_type pending_offsets[$];   // offsets still owed by the block

   // Traffic control shared between processes.
   bit tx_steady   = 1'b0;
   bit rx_steady   = 1'b0;
   bit rx_hold_req = 1'b0;

   int unsigned requests_sent   = 0;
   int unsigned offsets_checked = 0;
   int unsigned mismatch_count  = 0;
   int unsigned reg_writes      = 0;
   int unsigned full_cycles     = 0;
   int unsigned cycle_count     = 0;

   // Clamp the group count register to 1..MAX_GROUPS.
   function automatic logic [GRID_BITS-1:0] active_groups();
      if (cfg_grid_cols == 0)
         return 5'd1;
      if (cfg_grid_cols > DEFAULT_MAX_GROUPS)
         return 5'(DEFAULT_MAX_GROUPS);
      return cfg_grid_cols;
   endfunction

   // First column of group g: leading wide groups hold one extra column each.
   function automatic logic [63:0] first_column_of(logic [GRID_BITS-1:0] g);
      logic [63:0] extra;
      extra = (g < cfg_wide_groups) ? 64'(g) : 64'(cfg_wide_groups);
      return 64'(g) * 64'(cfg_group_width) + extra;
   endfunction

   function automatic logic [DATA_BITS-1:0] bump(logic [DATA_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic void note_offset(logic [DATA_BITS-1:0] off,
                                       logic [GROUP_NUM_BITS-1:0] grp, logic fin);
      rsp_type r;
      r.offset       = off;
      r.row_number   = rows_closed;
      r.group_number = grp;
      r.is_final     = fin;
      r.last         = 1'b0;
      fresh_offsets.push_back(r);
   endfunction

   function automatic void move_to_group(logic [GRID_BITS-1:0] g);
      pending_group = g;
      pending_start = first_column_of(g);
   endfunction

   // Group 0 of a row always starts at the row's first index.
   function automatic void start_row();
      note_offset(nnz_seen, '0, 1'b0);
      move_to_group(5'd1);
      row_in_progress = 1'b1;
   endfunction

   // Flush the remaining groups of the row, all at the current index.
   function automatic void finish_row(logic [GRID_BITS-1:0] groups);
      if (!row_in_progress)
         start_row();
      while (pending_group < groups) begin
         note_offset(nnz_seen, pending_group[GROUP_NUM_BITS-1:0], 1'b0);
         move_to_group(5'(pending_group + 1'b1));
      end
      row_in_progress = 1'b0;
      move_to_group('0);
      rows_closed = bump(rows_closed);
   endfunction

   function automatic void walk_groups(logic [1:0] code, logic [DATA_BITS-1:0] col);
      logic [GRID_BITS-1:0] groups;
      groups = active_groups();
      case (code)
         REQ_ENTRY: begin
            if (!row_in_progress)
               start_row();
            pending_start = first_column_of(pending_group);
            // Groups only move forward; a column behind the pending group adds nothing.
            while (pending_group < groups && 64'(col) >= pending_start) begin
               note_offset(nnz_seen, pending_group[GROUP_NUM_BITS-1:0], 1'b0);
               move_to_group(5'(pending_group + 1'b1));
            end
            nnz_seen = bump(nnz_seen);
         end
         REQ_ROW_END: begin
            finish_row(groups);
         end
         REQ_MATRIX_END: begin
            if (row_in_progress)
               finish_row(groups);
            note_offset(nnz_seen, '0, 1'b1);
            nnz_seen    = '0;
            rows_closed = '0;
            move_to_group('0);
         end
         default: begin
            // unknown code: drop it
         end
      endcase
      if (fresh_offsets.size() > 0)
         fresh_offsets[$].last = 1'b1;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap(bit steady);
      int unsigned r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Compare one popped offset with the oldest one owed.
   function automatic void check_offset(rsp_type got);
      rsp_type want;
      if (pending_offsets.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected offset %0d row %0d group %0d final %0b last %0b",
                     $realtime, got.offset, got.row_number, got.group_number,
                     got.is_final, got.last);
         return;
      end
      want = pending_offsets.pop_front();
      offsets_checked++;
      if (got.offset !== want.offset || got.row_number !== want.row_number ||
          got.group_number !== want.group_number || got.is_final !== want.is_final ||
          got.last !== want.last) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: mismatch on offset transfer %0d", $realtime, offsets_checked);
            $display("   expected offset %0d row %0d group %0d final %0b last %0b",
                     want.offset, want.row_number, want.group_number,
                     want.is_final, want.last);
            $display("   actual   offset %0d row %0d group %0d final %0b last %0b",
                     got.offset, got.row_number, got.group_number, got.is_final, got.last);
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Request side. Drive at the rising edge; the transfer is the first edge
   // with push high and full low. Push stays high across back-to-back
   // requests so it is never lowered and raised in one step.
   // ------------------------------------------------------------------
   task automatic offer_request(logic [1:0] code, logic [DATA_BITS-1:0] col,
                                bit typed, rsp_type want);
      int unsigned gap;
      push       <= 1'b1;
      req_type   <= code;
      req_column <= col;
      do
         @(posedge clock);
      while (full);
      walk_groups(code, col);
      if (typed)
         pending_offsets.push_back(want);
      else
         foreach (fresh_offsets[i])
            pending_offsets.push_back(fresh_offsets[i]);
      fresh_offsets.delete();
      if (code != REQ_UNKNOWN)
         requests_sent++;
      gap = pick_gap(tx_steady);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop push, wait until every owed offset is back, then let the walker
   // finish any request that produces nothing.
   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (pending_offsets.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_GRID_COLS:   cfg_grid_cols   = val[GRID_BITS-1:0];
         CSR_GROUP_WIDTH: cfg_group_width = val[DATA_BITS-1:0];
         CSR_WIDE_GROUPS: cfg_wide_groups = val[WIDE_BITS-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // Random register setting; out-of-range group counts and extreme widths
   // show up now and then.
   task automatic load_random_setting();
      logic [DATA_BITS-1:0] width;
      logic [GRID_BITS-1:0] grid;
      case ($urandom_range(0, 7))
         0:       width = $urandom;
         1:       width = '1;
         2:       width = '0;
         default: width = $urandom_range(1, 6);
      endcase
      if ($urandom_range(0, 5) == 0)
         grid = 5'($urandom_range(0, 31));
      else
         grid = 5'($urandom_range(1, 16));
      write_reg(CSR_GRID_COLS, 32'(grid));
      write_reg(CSR_GROUP_WIDTH, width);
      write_reg(CSR_WIDE_GROUPS, 32'($urandom_range(0, 15)));
   endtask

   // One matrix of well-formed rows with ascending columns spread over the
   // column range, plus dropped codes, out-of-order columns and an open last
   // row mixed in.
   task automatic send_random_matrix();
      int unsigned          rows;
      int unsigned          entries;
      logic [63:0]          span;
      logic [DATA_BITS-1:0] step;
      logic [DATA_BITS-1:0] col;
      span = 64'(active_groups()) * 64'(cfg_group_width) + 64'(cfg_wide_groups);
      step = (span >= 64'h1_0000_0000) ? '1 : span[DATA_BITS-1:0] / 4 + 1;
      rows = $urandom_range(0, 4);
      for (int r = 0; r < rows; r++) begin
         entries = $urandom_range(0, 5);
         col = $urandom_range(0, step);
         for (int e = 0; e < entries; e++) begin
            if ($urandom_range(0, 15) == 0)
               offer_request(REQ_UNKNOWN, $urandom, 1'b0, NO_RSP);
            if ($urandom_range(0, 9) == 0)
               col = $urandom;
            offer_request(REQ_ENTRY, col, 1'b0, NO_RSP);
            col = col + $urandom_range(0, step);
         end
         if (r + 1 < rows || $urandom_range(0, 2) != 0)
            offer_request(REQ_ROW_END, $urandom, 1'b0, NO_RSP);
      end
      offer_request(REQ_MATRIX_END, $urandom, 1'b0, NO_RSP);
   endtask

   // ------------------------------------------------------------------
   // Directed plan: reset defaults, extreme columns, every request type,
   // empty rows, rows left open at end of matrix, group count 0 and above
   // the maximum, zero and maximal widths, out-of-order columns and a new
   // matrix after the end of the previous one.
   // ------------------------------------------------------------------
   plan_row_t directed_plan [PLAN_ROWS] = '{
      '{STEP_ITEM, REQ_ENTRY,       32'h0,        1'b1, '{32'd0, 32'd0, 4'd0, 1'b0, 1'b1}},
      '{STEP_ITEM, REQ_ENTRY,       32'hFFFF_FFFF, 1'b0, NO_RSP},
      '{STEP_ITEM, REQ_MATRIX_END,  32'h0,        1'b1, '{32'd2, 32'd1, 4'd0, 1'b1, 1'b1}},
      '{STEP_ITEM, REQ_UNKNOWN,     32'hFFFF_FFFF, 1'b0, NO_RSP},
      '{STEP_ITEM, REQ_MATRIX_END,  32'hFFFF_FFFF, 1'b1, '{32'd0, 32'd0, 4'd0, 1'b1, 1'b1}},
      '{STEP_CSR,  CSR_GRID_COLS,   32'd16,        1'b0, NO_RSP},
      '{STEP_CSR,  CSR_GROUP_WIDTH, 32'hFFFF_FFFF, 1'b0, NO_RSP},
      '{STEP_CSR,  CSR_WIDE_GROUPS, 32'd15,        1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ROW_END,     32'h0,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ENTRY,       32'hFFFF_FFFF, 1'b1, '{32'd0, 32'd1, 4'd0, 1'b0, 1'b1}},
      '{STEP_ITEM, REQ_MATRIX_END,  32'h0,         1'b0, NO_RSP},
      '{STEP_CSR,  CSR_GRID_COLS,   32'd0,         1'b0, NO_RSP},
      '{STEP_CSR,  CSR_GROUP_WIDTH, 32'd0,         1'b0, NO_RSP},
      '{STEP_CSR,  CSR_WIDE_GROUPS, 32'd0,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ENTRY,       32'h0,         1'b1, '{32'd0, 32'd0, 4'd0, 1'b0, 1'b1}},
      '{STEP_ITEM, REQ_ROW_END,     32'h0,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_MATRIX_END,  32'h0,         1'b1, '{32'd1, 32'd1, 4'd0, 1'b1, 1'b1}},
      '{STEP_CSR,  CSR_GRID_COLS,   32'd31,        1'b0, NO_RSP},
      '{STEP_CSR,  CSR_GROUP_WIDTH, 32'd0,         1'b0, NO_RSP},
      '{STEP_CSR,  CSR_WIDE_GROUPS, 32'd0,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ENTRY,       32'h0,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ENTRY,       32'd5,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_MATRIX_END,  32'h0,         1'b0, NO_RSP},
      '{STEP_CSR,  CSR_GRID_COLS,   32'd4,         1'b0, NO_RSP},
      '{STEP_CSR,  CSR_GROUP_WIDTH, 32'd3,         1'b0, NO_RSP},
      '{STEP_CSR,  CSR_WIDE_GROUPS, 32'd2,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ENTRY,       32'd9,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ENTRY,       32'd2,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ENTRY,       32'd11,        1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ENTRY,       32'd12,        1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ROW_END,     32'h0,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ROW_END,     32'h0,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ENTRY,       32'd5,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_UNKNOWN,     32'd5,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_MATRIX_END,  32'h0,         1'b0, NO_RSP},
      '{STEP_ITEM, REQ_ENTRY,       32'h0,         1'b1, '{32'd0, 32'd0, 4'd0, 1'b0, 1'b1}},
      '{STEP_ITEM, REQ_MATRIX_END,  32'h0,         1'b0, NO_RSP}
   };

   // Count cycles in which the block refuses an offered request.
   always @(posedge clock) begin
      if (!reset && push && full)
         full_cycles++;
   end

   // ------------------------------------------------------------------
   // Result side: pop with random gaps; on request hold off for a long
   // stretch so the result queue and then the request queue fill up.
   // ------------------------------------------------------------------
   initial begin : drain_offsets
      int unsigned gap;
      rsp_type     got;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (rx_hold_req) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rx_hold_req = 1'b0;
         end else begin
            gap = pick_gap(rx_steady);
            if (gap > 0) begin
               pop <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         pop <= 1'b1;
         @(posedge clock);
         if (!empty) begin
            got.offset       = rsp_offset;
            got.row_number   = rsp_row_number;
            got.group_number = rsp_group_number;
            got.is_final     = rsp_is_final;
            got.last         = rsp_last;
            check_offset(got);
         end
      end
   end

   // Hard stop if the block hangs.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped at the cycle limit with %0d offsets still owed",
               pending_offsets.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      bit          quiet;
      int unsigned random_goal;
      int unsigned phases;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed plan; register writes wait for the block to drain.
      quiet = 1'b1;
      foreach (directed_plan[i]) begin
         if (directed_plan[i].action == STEP_CSR) begin
            if (!quiet)
               wait_idle();
            quiet = 1'b1;
            write_reg(directed_plan[i].code, directed_plan[i].value);
         end else begin
            quiet = 1'b0;
            offer_request(directed_plan[i].code, directed_plan[i].value,
                          directed_plan[i].typed, directed_plan[i].want);
         end
      end

      // Back pressure: hold the receiver off while empty rows of 16 groups
      // pour in with no gaps, so full has to rise.
      wait_idle();
      write_reg(CSR_GRID_COLS, 32'd16);
      write_reg(CSR_GROUP_WIDTH, 32'd2);
      write_reg(CSR_WIDE_GROUPS, 32'd3);
      tx_steady   = 1'b1;
      rx_hold_req = 1'b1;
      repeat (10) offer_request(REQ_ROW_END, $urandom, 1'b0, NO_RSP);
      offer_request(REQ_MATRIX_END, $urandom, 1'b0, NO_RSP);

      // Random phases: new setting, new traffic mix, a few matrices each.
      random_goal = requests_sent + RANDOM_ITEMS;
      phases = 0;
      while (requests_sent < random_goal) begin
         wait_idle();
         load_random_setting();
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) send_random_matrix();
         phases++;
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;

      wait_idle();
      $display("Covered %0d requests over %0d random settings and %0d register writes,",
               requests_sent, phases, reg_writes);
      $display("%0d offsets checked, %0d mismatches, request side blocked %0d cycles.",
               offsets_checked, mismatch_count, full_cycles);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
